>>> rtl/pafc_pkg.sv
`timescale 1ns / 1ps

package pafc_pkg;

    localparam int C_COUNT_WIDTH = 16;
    localparam int C_CFG_IDX_W   = 3;
    localparam int C_CFG_DATA_W  = 12;
    localparam int C_HALF_MS_W   = 12;
    localparam int C_DELAY_W     = 4;
    localparam int C_PULSE_W     = 8;
    localparam int C_MODE_W      = 3;
    localparam int C_PROD_W      = C_HALF_MS_W + C_DELAY_W;

    localparam logic [C_CFG_IDX_W-1:0] REG_HALF_MS_TICKS = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] REG_MIN_DELAY     = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] REG_MAX_DELAY     = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] REG_LOW_PRESET    = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] REG_MID_PRESET    = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] REG_HIGH_PRESET   = 3'd5;
    localparam logic [C_CFG_IDX_W-1:0] REG_PULSE_TICKS   = 3'd6;

    localparam logic [C_HALF_MS_W-1:0] RST_HALF_MS_TICKS = 12'd1000;
    localparam logic [C_DELAY_W-1:0]   RST_MIN_DELAY     = 4'd2;
    localparam logic [C_DELAY_W-1:0]   RST_MAX_DELAY     = 4'd14;
    localparam logic [C_DELAY_W-1:0]   RST_LOW_PRESET    = 4'd12;
    localparam logic [C_DELAY_W-1:0]   RST_MID_PRESET    = 4'd8;
    localparam logic [C_DELAY_W-1:0]   RST_HIGH_PRESET   = 4'd4;
    localparam logic [C_PULSE_W-1:0]   RST_PULSE_TICKS   = 8'd40;
    localparam logic [C_DELAY_W-1:0]   RST_DELAY         = 4'd2;

    typedef enum logic [C_MODE_W-1:0] {
        MODE_NORMAL = 3'd0,
        MODE_OFF    = 3'd1,
        MODE_LOW    = 3'd2,
        MODE_MEDIUM = 3'd3,
        MODE_HIGH   = 3'd4
    } t_mode;

    typedef struct packed {
        logic tick;
        logic dec_press;
        logic inc_press;
        logic mode_press;
        logic zero_cross;
    } t_in;

    typedef struct packed {
        logic                 gate;
        logic                 fired;
        logic [C_DELAY_W-1:0] delay_now;
        logic [C_MODE_W-1:0]  mode_now;
        logic                 counting;
    } t_out;

    typedef struct packed {
        logic [C_HALF_MS_W-1:0] half_ms_ticks;
        logic [C_DELAY_W-1:0]   min_delay;
        logic [C_DELAY_W-1:0]   max_delay;
        logic [C_DELAY_W-1:0]   low_preset;
        logic [C_DELAY_W-1:0]   mid_preset;
        logic [C_DELAY_W-1:0]   high_preset;
        logic [C_PULSE_W-1:0]   pulse_ticks;
    } t_cfg;

endpackage

>>> rtl/pafc_cfg_regs.sv
`timescale 1ns / 1ps

module pafc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pafc_pkg::C_CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [pafc_pkg::C_CFG_DATA_W-1:0] i_cfg_wdata,
    output pafc_pkg::t_cfg                    o_cfg
);
    import pafc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_ms_ticks <= RST_HALF_MS_TICKS;
            r_cfg.min_delay     <= RST_MIN_DELAY;
            r_cfg.max_delay     <= RST_MAX_DELAY;
            r_cfg.low_preset    <= RST_LOW_PRESET;
            r_cfg.mid_preset    <= RST_MID_PRESET;
            r_cfg.high_preset   <= RST_HIGH_PRESET;
            r_cfg.pulse_ticks   <= RST_PULSE_TICKS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_HALF_MS_TICKS: r_cfg.half_ms_ticks <= i_cfg_wdata[C_HALF_MS_W-1:0];
                REG_MIN_DELAY:     r_cfg.min_delay     <= i_cfg_wdata[C_DELAY_W-1:0];
                REG_MAX_DELAY:     r_cfg.max_delay     <= i_cfg_wdata[C_DELAY_W-1:0];
                REG_LOW_PRESET:    r_cfg.low_preset    <= i_cfg_wdata[C_DELAY_W-1:0];
                REG_MID_PRESET:    r_cfg.mid_preset    <= i_cfg_wdata[C_DELAY_W-1:0];
                REG_HIGH_PRESET:   r_cfg.high_preset   <= i_cfg_wdata[C_DELAY_W-1:0];
                REG_PULSE_TICKS:   r_cfg.pulse_ticks   <= i_cfg_wdata[C_PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/pafc_fire_logic.sv
`timescale 1ns / 1ps

module pafc_fire_logic #(
    parameter int COUNT_WIDTH = pafc_pkg::C_COUNT_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  pafc_pkg::t_in  i_item,
    input  pafc_pkg::t_cfg i_cfg,
    output pafc_pkg::t_out o_res
);
    import pafc_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > C_PROD_W) ? COUNT_WIDTH : C_PROD_W;

    t_mode                  r_mode;
    logic [C_DELAY_W-1:0]   r_delay;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_run;
    logic [C_PULSE_W-1:0]   r_pulse;

    t_mode                  n_mode;
    logic [C_DELAY_W-1:0]   n_delay;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_run;
    logic [C_PULSE_W-1:0]   n_pulse;
    logic                   fired;

    logic [C_PROD_W-1:0]    prod;
    logic [EXT_W-1:0]       prod_m1;
    logic [EXT_W-1:0]       cnt_max_ext;
    logic [COUNT_WIDTH-1:0] cmp;

    always_comb begin
        n_delay = r_delay;
        n_mode  = r_mode;
        n_count = r_count;
        n_run   = r_run;
        n_pulse = r_pulse;
        fired   = 1'b0;

        if (i_item.dec_press && (n_delay > i_cfg.min_delay)) begin
            n_delay = n_delay - 1'b1;
        end
        if (i_item.inc_press && (n_delay < i_cfg.max_delay)) begin
            n_delay = n_delay + 1'b1;
        end

        if (i_item.mode_press) begin
            case (r_mode)
                MODE_NORMAL: begin
                    n_mode = MODE_OFF;
                    n_run  = 1'b0;
                end
                MODE_OFF: begin
                    n_mode  = MODE_LOW;
                    n_delay = i_cfg.low_preset;
                    n_run   = 1'b0;
                end
                MODE_LOW: begin
                    n_mode  = MODE_MEDIUM;
                    n_delay = i_cfg.mid_preset;
                    n_run   = 1'b0;
                end
                MODE_MEDIUM: begin
                    n_mode  = MODE_HIGH;
                    n_delay = i_cfg.high_preset;
                    n_run   = 1'b0;
                end
                default: begin
                    n_mode = MODE_NORMAL;
                end
            endcase
        end

        if (i_item.zero_cross) begin
            n_count = '0;
            n_run   = 1'b1;
        end

        // compare value, saturated to the counter range
        prod        = C_PROD_W'(i_cfg.half_ms_ticks) * C_PROD_W'(n_delay);
        prod_m1     = EXT_W'(prod) - EXT_W'(1);
        cnt_max_ext = EXT_W'({COUNT_WIDTH{1'b1}});
        if (prod == '0) begin
            cmp = '0;
        end else if (prod_m1 > cnt_max_ext) begin
            cmp = {COUNT_WIDTH{1'b1}};
        end else begin
            cmp = prod_m1[COUNT_WIDTH-1:0];
        end

        if (n_count > cmp) begin
            n_count = '0;
        end

        if (i_item.tick) begin
            if (n_pulse != '0) begin
                n_pulse = n_pulse - 1'b1;
            end
            if (n_run && (n_mode != MODE_OFF)) begin
                if (n_count == cmp) begin
                    n_count = '0;
                    n_run   = 1'b0;
                    fired   = 1'b1;
                    n_pulse = i_cfg.pulse_ticks;
                end else begin
                    n_count = n_count + 1'b1;
                end
            end
        end

        o_res.gate      = (n_pulse != '0);
        o_res.fired     = fired;
        o_res.delay_now = n_delay;
        o_res.mode_now  = n_mode;
        o_res.counting  = n_run && (n_mode != MODE_OFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_delay <= RST_DELAY;
            r_count <= '0;
            r_run   <= 1'b0;
            r_pulse <= '0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_delay <= n_delay;
            r_count <= n_count;
            r_run   <= n_run;
            r_pulse <= n_pulse;
        end
    end

endmodule

>>> rtl/phase_angle_firing_controller_core.sv
`timescale 1ns / 1ps

// Triac phase-angle firing controller. Takes one item per clock while the output
// side keeps up and returns one result item for each; a result passes through the
// input register, then the result register, and is offered from there until the
// output side is ready to take it. The state update, holding the half_ms_ticks by
// delay multiply and the counter compare, is combinational and sets the
// one-item-per-cycle rate. The user must write configuration through the plain
// write port only while no item is in flight; the block itself does not enforce it.
module phase_angle_firing_controller_core #(
    parameter int COUNT_WIDTH = pafc_pkg::C_COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pafc_pkg::C_CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [pafc_pkg::C_CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pafc_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pafc_pkg::t_out                    o_out_data
);
    import pafc_pkg::*;

    t_cfg   cfg;
    t_in    r_in;
    logic   r_in_valid;
    t_out   r_out;
    logic   r_out_valid;
    t_out   res;
    logic   adv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    pafc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pafc_fire_logic #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fire (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> bench/phase_angle_firing_controller_core_tb.sv
`timescale 1ns / 1ps

module phase_angle_firing_controller_core_tb;
    import pafc_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_SETTINGS   = 6;

    class firing_scoreboard;
        t_cfg                     regs;
        t_mode                    mode;
        logic [C_DELAY_W-1:0]     delay;
        logic [C_COUNT_WIDTH-1:0] count;
        bit                       run;
        logic [C_PULSE_W-1:0]     pulse;
        t_out                     pending_results[$];
        int                       errors;
        int                       items_noted;
        int                       results_seen;
        int                       firings;

        function new();
            regs.half_ms_ticks = RST_HALF_MS_TICKS;
            regs.min_delay     = RST_MIN_DELAY;
            regs.max_delay     = RST_MAX_DELAY;
            regs.low_preset    = RST_LOW_PRESET;
            regs.mid_preset    = RST_MID_PRESET;
            regs.high_preset   = RST_HIGH_PRESET;
            regs.pulse_ticks   = RST_PULSE_TICKS;
            mode  = MODE_NORMAL;
            delay = RST_DELAY;
            count = '0;
            run   = 1'b0;
            pulse = '0;
            errors = 0;
            items_noted = 0;
            results_seen = 0;
            firings = 0;
        endfunction

        function void set_reg(logic [C_CFG_IDX_W-1:0] idx, logic [C_CFG_DATA_W-1:0] val);
            case (idx)
                REG_HALF_MS_TICKS: regs.half_ms_ticks = val[C_HALF_MS_W-1:0];
                REG_MIN_DELAY:     regs.min_delay     = val[C_DELAY_W-1:0];
                REG_MAX_DELAY:     regs.max_delay     = val[C_DELAY_W-1:0];
                REG_LOW_PRESET:    regs.low_preset    = val[C_DELAY_W-1:0];
                REG_MID_PRESET:    regs.mid_preset    = val[C_DELAY_W-1:0];
                REG_HIGH_PRESET:   regs.high_preset   = val[C_DELAY_W-1:0];
                REG_PULSE_TICKS:   regs.pulse_ticks   = val[C_PULSE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [C_COUNT_WIDTH-1:0] fire_point();
            longint unsigned prod;
            longint unsigned top;
            prod = longint'(regs.half_ms_ticks) * longint'(delay);
            top  = (64'd1 << C_COUNT_WIDTH) - 64'd1;
            if (prod == 0)
                return '0;
            if (prod - 1 > top)
                return top[C_COUNT_WIDTH-1:0];
            return C_COUNT_WIDTH'(prod - 1);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_item(t_in item);
            logic [C_COUNT_WIDTH-1:0] cmp;
            t_out want;
            bit   fired;
            fired = 1'b0;
            if (item.dec_press && delay > regs.min_delay)
                delay = delay - 1'b1;
            if (item.inc_press && delay < regs.max_delay)
                delay = delay + 1'b1;
            if (item.mode_press) begin
                case (mode)
                    MODE_NORMAL: begin
                        mode = MODE_OFF;
                        run  = 1'b0;
                    end
                    MODE_OFF: begin
                        mode  = MODE_LOW;
                        delay = regs.low_preset;
                        run   = 1'b0;
                    end
                    MODE_LOW: begin
                        mode  = MODE_MEDIUM;
                        delay = regs.mid_preset;
                        run   = 1'b0;
                    end
                    MODE_MEDIUM: begin
                        mode  = MODE_HIGH;
                        delay = regs.high_preset;
                        run   = 1'b0;
                    end
                    default: mode = MODE_NORMAL;
                endcase
            end
            if (item.zero_cross) begin
                count = '0;
                run   = 1'b1;
            end
            cmp = fire_point();
            // lowered compare value restarts the count without firing
            if (count > cmp)
                count = '0;
            if (item.tick) begin
                if (pulse != 0)
                    pulse = pulse - 1'b1;
                if (run && mode != MODE_OFF) begin
                    if (count == cmp) begin
                        count = '0;
                        run   = 1'b0;
                        fired = 1'b1;
                        pulse = regs.pulse_ticks;
                    end else begin
                        count = count + 1'b1;
                    end
                end
            end
            want.gate      = (pulse != 0);
            want.fired     = fired;
            want.delay_now = delay;
            want.mode_now  = mode;
            want.counting  = run && mode != MODE_OFF;
            if (fired)
                firings++;
            items_noted++;
            pending_results.push_back(want);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                report("result item with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            if (got.gate !== want.gate)
                report($sformatf("result %0d gate got %0b want %0b",
                                 results_seen, got.gate, want.gate));
            if (got.fired !== want.fired)
                report($sformatf("result %0d fired got %0b want %0b",
                                 results_seen, got.fired, want.fired));
            if (got.delay_now !== want.delay_now)
                report($sformatf("result %0d delay_now got %0d want %0d",
                                 results_seen, got.delay_now, want.delay_now));
            if (got.mode_now !== want.mode_now)
                report($sformatf("result %0d mode_now got %0d want %0d",
                                 results_seen, got.mode_now, want.mode_now));
            if (got.counting !== want.counting)
                report($sformatf("result %0d counting got %0b want %0b",
                                 results_seen, got.counting, want.counting));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [C_CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [C_CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    o_in_ready;
    t_in                     in_data = '0;
    logic                    o_out_valid;
    logic                    out_ready = 1'b0;
    t_out                    o_out_data;

    logic                    hold_req = 1'b0;
    int                      send_calm = 0;
    int                      recv_calm = 0;
    int                      settings_used = 0;
    t_cfg                    plan [N_SETTINGS];

    firing_scoreboard sb = new();

    phase_angle_firing_controller_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int draw_gap(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            calm = $urandom_range(30, 80);
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic t_in mk(bit tick, bit dec, bit inc, bit mode, bit zc);
        t_in it;
        it.tick       = tick;
        it.dec_press  = dec;
        it.inc_press  = inc;
        it.mode_press = mode;
        it.zero_cross = zc;
        return it;
    endfunction

    // mains-like traffic: zero crossings followed by runs of ticks, some noise
    function automatic t_in random_item();
        t_in it;
        if ($urandom_range(0, 9) == 0) begin
            it = t_in'(5'($urandom_range(0, 31)));
        end else begin
            it.tick       = ($urandom_range(0, 99) < 85);
            it.dec_press  = ($urandom_range(0, 99) < 4);
            it.inc_press  = ($urandom_range(0, 99) < 4);
            it.mode_press = ($urandom_range(0, 99) < 3);
            it.zero_cross = ($urandom_range(0, 99) < 5);
        end
        return it;
    endfunction

    task automatic send_item(input t_in item);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(item);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx,
                             input logic [C_CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(input t_cfg s);
        write_reg(REG_HALF_MS_TICKS, C_CFG_DATA_W'(s.half_ms_ticks));
        write_reg(REG_MIN_DELAY,     C_CFG_DATA_W'(s.min_delay));
        write_reg(REG_MAX_DELAY,     C_CFG_DATA_W'(s.max_delay));
        write_reg(REG_LOW_PRESET,    C_CFG_DATA_W'(s.low_preset));
        write_reg(REG_MID_PRESET,    C_CFG_DATA_W'(s.mid_preset));
        write_reg(REG_HIGH_PRESET,   C_CFG_DATA_W'(s.high_preset));
        write_reg(REG_PULSE_TICKS,   C_CFG_DATA_W'(s.pulse_ticks));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial begin : receiver
        int  stall;
        bit  held;
        stall = 0;
        held  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && out_ready)
                sb.check_result(o_out_data);
            if (hold_req && !held) begin
                // long hold-off so the block fills and stalls its input
                held  = 1'b1;
                stall = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall = draw_gap(recv_calm);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles", quiet);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : main
        int ph;
        int k;
        // hm, min, max, low, mid, high, pulse
        plan[0] = '{12'd1,    4'd1,  4'd15, 4'd12, 4'd8,  4'd4,  8'd3};
        plan[1] = '{12'd2,    4'd2,  4'd14, 4'd12, 4'd8,  4'd4,  8'd40};
        plan[2] = '{12'd0,    4'd0,  4'd15, 4'd0,  4'd15, 4'd0,  8'd0};
        plan[3] = '{12'd4095, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 8'd255};
        plan[4] = '{12'd3,    4'd5,  4'd3,  4'd1,  4'd2,  4'd3,  8'd1};
        plan[5] = '{12'd1,    4'd0,  4'd15, 4'd5,  4'd10, 4'd15, 8'd255};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: quiet item, every event at once, full mode cycle, dec floor
        send_item(mk(0, 0, 0, 0, 0));
        send_item(mk(1, 1, 1, 1, 1));
        send_item(mk(1, 0, 0, 0, 0));
        for (k = 0; k < 4; k++)
            send_item(mk(0, 0, 0, 1, 0));
        for (k = 0; k < 3; k++)
            send_item(mk(0, 1, 0, 0, 0));
        settle();

        // one tick per half ms: fire, pulse run-out, off mode behaviour
        apply_settings(plan[0]);
        send_item(mk(0, 0, 0, 0, 1));
        for (k = 0; k < 4; k++)
            send_item(mk(1, 0, 0, 0, 0));
        send_item(mk(1, 0, 1, 0, 1));
        send_item(mk(1, 0, 0, 0, 0));
        send_item(mk(0, 0, 0, 1, 0));
        send_item(mk(1, 0, 0, 0, 0));
        send_item(mk(1, 0, 0, 0, 1));
        send_item(mk(1, 0, 0, 1, 0));
        for (k = 0; k < 4; k++)
            send_item(mk(1, 0, 0, 0, 0));

        for (ph = 0; ph < N_SETTINGS; ph++) begin
            settle();
            apply_settings(plan[ph]);
            if (ph == 1)
                hold_req <= 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_item(random_item());
        end
        settle();

        $display("checked %0d result items from %0d input items, %0d gate firings",
                 sb.results_seen, sb.items_noted, sb.firings);
        $display("register settings applied: %0d, including zero and all-ones values",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
